>>> rtl/db_hrp_pkg.sv
// shared constants of the handshake response parser
package db_hrp_pkg;

    localparam logic [5:0] FIXED_PART_LEN = 6'(4 + 4 + 4 + 1 + 23);

    localparam int CAP_CONNECT_DB_BIT = 3;
    localparam int CAP_SSL_BIT        = 11;

    localparam logic [3:0] KIND_HDR      = 4'd0;
    localparam logic [3:0] KIND_CAPS     = 4'd1;
    localparam logic [3:0] KIND_MAXPKT   = 4'd2;
    localparam logic [3:0] KIND_CHARSET  = 4'd3;
    localparam logic [3:0] KIND_RESERVED = 4'd4;
    localparam logic [3:0] KIND_USER     = 4'd5;
    localparam logic [3:0] KIND_USER_END = 4'd6;
    localparam logic [3:0] KIND_TOKLEN   = 4'd7;
    localparam logic [3:0] KIND_TOKEN    = 4'd8;
    localparam logic [3:0] KIND_DB       = 4'd9;
    localparam logic [3:0] KIND_DB_END   = 4'd10;
    localparam logic [3:0] KIND_IGNORED  = 4'd11;

    localparam logic [2:0] REG_USER_MAX_LEN = 3'd0;
    localparam logic [2:0] REG_DB_MAX_LEN   = 3'd4;

endpackage

>>> rtl/db_handshake_response_parser_core.sv
// handshake response parser: tags each packet byte and reports the packet summary
// a word accepted into the input register moves on into the result register once that is free
// throughput: one word per cycle while the result channel is not stalled, set by the
//   phase update between the input register and the result register
// reset (i_rst_n low, synchronous): both stages empty, parser back at the fixed header,
//   all running values zero, length limits back to 128
module db_handshake_response_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_field_kind,
    output logic [7:0]  o_byte_echo,
    output logic        o_packet_done,
    output logic        o_parse_failed,
    output logic [31:0] o_capability_word,
    output logic [7:0]  o_charset_code,
    output logic [7:0]  o_user_name_len,
    output logic [7:0]  o_token_length,
    output logic [7:0]  o_db_length,
    output logic        o_ssl_capable,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // parse phases of one packet
    typedef enum logic [2:0] {
        PH_FIXED  = 3'd0,
        PH_USER   = 3'd1,
        PH_TOKLEN = 3'd2,
        PH_TOKEN  = 3'd3,
        PH_DB     = 3'd4,
        PH_TAIL   = 3'd5
    } t_phase;

    // configuration registers
    logic [7:0] r_user_max;
    logic [7:0] r_db_max;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;

    // per-packet parser state
    t_phase      r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_caps, n_caps;
    logic [7:0]  r_charset, n_charset;
    logic [7:0]  r_user_cnt, n_user_cnt;
    logic [7:0]  r_tok_len, n_tok_len;
    logic [7:0]  r_tok_rem, n_tok_rem;
    logic [7:0]  r_db_cnt, n_db_cnt;
    logic        r_fail, n_fail;
    logic [3:0]  n_kind;
    logic [7:0]  tok_rem_dec;
    t_phase      after_token;

    // result register
    logic        r_out_valid;
    logic [3:0]  r_kind;
    logic [7:0]  r_echo;
    logic        r_done;
    logic        r_failed;
    logic [31:0] r_out_caps;
    logic [7:0]  r_out_charset;
    logic [7:0]  r_out_user;
    logic [7:0]  r_out_tok;
    logic [7:0]  r_out_db;

    logic out_free;
    logic fire;
    logic cfg_wr;

    // result register can take a word when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    // input register only holds back when it is full and cannot move on
    assign o_in_stall = r_in_valid && !out_free;

    // apb: zero wait states, register picked by address bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {24'd0, paddr[2] ? r_db_max : r_user_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_user_max <= 8'd128;
            r_db_max   <= 8'd128;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_db_max <= pwdata[7:0];
            end else begin
                r_user_max <= pwdata[7:0];
            end
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // token length counted down; a zero length means no token bytes follow
    assign tok_rem_dec = r_tok_rem - 8'd1;
    assign after_token = r_caps[db_hrp_pkg::CAP_CONNECT_DB_BIT] ? PH_DB : PH_TAIL;

    // phase logic for the word in the input register
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_caps     = r_caps;
        n_charset  = r_charset;
        n_user_cnt = r_user_cnt;
        n_tok_len  = r_tok_len;
        n_tok_rem  = r_tok_rem;
        n_db_cnt   = r_db_cnt;
        n_fail     = r_fail;
        n_kind     = db_hrp_pkg::KIND_IGNORED;
        case (r_phase)
            PH_FIXED: begin
                if (r_pos < 6'd4) begin
                    n_kind = db_hrp_pkg::KIND_HDR;
                end else if (r_pos < 6'd8) begin
                    // little-endian capability word, first byte restarts it
                    n_kind = db_hrp_pkg::KIND_CAPS;
                    if (r_pos == 6'd4) begin
                        n_caps = {24'd0, r_in_data};
                    end else begin
                        n_caps = r_caps | ({24'd0, r_in_data} << {r_pos[1:0], 3'b000});
                    end
                end else if (r_pos < 6'd12) begin
                    n_kind = db_hrp_pkg::KIND_MAXPKT;
                end else if (r_pos == 6'd12) begin
                    n_kind    = db_hrp_pkg::KIND_CHARSET;
                    n_charset = r_in_data;
                end else begin
                    n_kind = db_hrp_pkg::KIND_RESERVED;
                end
                if (r_pos >= db_hrp_pkg::FIXED_PART_LEN - 6'd1) begin
                    n_phase = PH_USER;
                end else begin
                    // packet ended inside the fixed part
                    n_pos = r_pos + 6'd1;
                    if (r_in_last) begin
                        n_fail = 1'b1;
                    end
                end
            end
            PH_USER: begin
                if (r_in_data != 8'd0) begin
                    n_kind = db_hrp_pkg::KIND_USER;
                    if (r_user_cnt >= r_user_max || r_in_last) begin
                        n_fail = 1'b1;
                    end
                    if (r_user_cnt != 8'hFF) begin
                        n_user_cnt = r_user_cnt + 8'd1;
                    end
                end else begin
                    n_kind  = db_hrp_pkg::KIND_USER_END;
                    n_phase = PH_TOKLEN;
                end
            end
            PH_TOKLEN: begin
                n_kind    = db_hrp_pkg::KIND_TOKLEN;
                n_tok_len = r_in_data;
                n_tok_rem = r_in_data;
                if (r_in_data == 8'd0) begin
                    n_phase = after_token;
                end else begin
                    n_phase = PH_TOKEN;
                    if (r_in_last) begin
                        n_fail = 1'b1;
                    end
                end
            end
            PH_TOKEN: begin
                n_kind    = db_hrp_pkg::KIND_TOKEN;
                n_tok_rem = tok_rem_dec;
                if (tok_rem_dec == 8'd0) begin
                    n_phase = after_token;
                end else if (r_in_last) begin
                    n_fail = 1'b1;
                end
            end
            PH_DB: begin
                if (r_in_data != 8'd0) begin
                    n_kind = db_hrp_pkg::KIND_DB;
                    if (r_db_cnt >= r_db_max || r_in_last) begin
                        n_fail = 1'b1;
                    end
                    if (r_db_cnt != 8'hFF) begin
                        n_db_cnt = r_db_cnt + 8'd1;
                    end
                end else begin
                    n_kind  = db_hrp_pkg::KIND_DB_END;
                    n_phase = PH_TAIL;
                end
            end
            default: begin
                // trailing bytes, and any code that means nothing
                n_kind  = db_hrp_pkg::KIND_IGNORED;
                n_phase = PH_TAIL;
            end
        endcase
    end

    // parser state and result register: the state moves as the word enters
    // the result register and is cleared after the last word of a packet;
    // the result carries running values after this word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIXED;
            r_pos       <= 6'd0;
            r_caps      <= 32'd0;
            r_charset   <= 8'd0;
            r_user_cnt  <= 8'd0;
            r_tok_len   <= 8'd0;
            r_tok_rem   <= 8'd0;
            r_db_cnt    <= 8'd0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire && r_in_last) begin
                r_phase    <= PH_FIXED;
                r_pos      <= 6'd0;
                r_caps     <= 32'd0;
                r_charset  <= 8'd0;
                r_user_cnt <= 8'd0;
                r_tok_len  <= 8'd0;
                r_tok_rem  <= 8'd0;
                r_db_cnt   <= 8'd0;
                r_fail     <= 1'b0;
            end else if (fire) begin
                r_phase    <= n_phase;
                r_pos      <= n_pos;
                r_caps     <= n_caps;
                r_charset  <= n_charset;
                r_user_cnt <= n_user_cnt;
                r_tok_len  <= n_tok_len;
                r_tok_rem  <= n_tok_rem;
                r_db_cnt   <= n_db_cnt;
                r_fail     <= n_fail;
            end
        end
        if (fire) begin
            r_kind        <= n_kind;
            r_echo        <= r_in_data;
            r_done        <= r_in_last;
            r_failed      <= r_in_last && n_fail;
            r_out_caps    <= n_caps;
            r_out_charset <= n_charset;
            r_out_user    <= n_user_cnt;
            r_out_tok     <= n_tok_len;
            r_out_db      <= n_db_cnt;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_field_kind      = r_kind;
    assign o_byte_echo       = r_echo;
    assign o_packet_done     = r_done;
    assign o_parse_failed    = r_failed;
    assign o_capability_word = r_out_caps;
    assign o_charset_code    = r_out_charset;
    assign o_user_name_len   = r_out_user;
    assign o_token_length    = r_out_tok;
    assign o_db_length       = r_out_db;
    assign o_ssl_capable     = r_out_caps[db_hrp_pkg::CAP_SSL_BIT];

endmodule

>>> rtl/db_hrp_checker.sv
// port-level checks on the handshake response parser, bound to the parser core module
module db_hrp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_field_kind,
    input logic [7:0]  o_byte_echo,
    input logic        o_packet_done,
    input logic        o_parse_failed,
    input logic [31:0] o_capability_word,
    input logic        o_ssl_capable
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_byte_echo)
            && $stable(o_field_kind) && $stable(o_packet_done)))
        else $error("stalled result word changed");

    // failure only reported on the last word
    a_fail_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_packet_done) |-> !o_parse_failed)
        else $error("failure flagged before end of packet");

    // packet ending before the reserved bytes is short
    a_short_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_packet_done && (o_field_kind == db_hrp_pkg::KIND_HDR
            || o_field_kind == db_hrp_pkg::KIND_CAPS
            || o_field_kind == db_hrp_pkg::KIND_MAXPKT
            || o_field_kind == db_hrp_pkg::KIND_CHARSET)) |-> o_parse_failed)
        else $error("short packet not flagged");

    // packet ending on an unterminated name fails
    a_open_name_fails: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_packet_done && (o_field_kind == db_hrp_pkg::KIND_USER
            || o_field_kind == db_hrp_pkg::KIND_DB)) |-> o_parse_failed)
        else $error("missing name terminator not flagged");

    // ssl flag follows the capability word
    a_ssl_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ssl_capable == o_capability_word[db_hrp_pkg::CAP_SSL_BIT]))
        else $error("ssl flag disagrees with capability word");

endmodule

bind db_handshake_response_parser_core db_hrp_checker u_db_hrp_checker (.*);
